// ===== rtl/core/mmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmhq_pkg
// Types and codes used by the min-max heap queue unit.
// ----------------------------------------------------------------------------
package mmhq_pkg;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_REM_MIN = 2'd1;
    localparam logic [1:0] OP_REM_MAX = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [10:0]        entry_count;
    } t_out;

    // a beats b on this level kind: larger on max levels, smaller on min levels
    function automatic logic beats(input logic signed [31:0] a,
                                   input logic signed [31:0] b,
                                   input logic mx);
        beats = mx ? (a > b) : (a < b);
    endfunction

endpackage

// ===== rtl/core/mmhq_ram.sv =====
// ----------------------------------------------------------------------------
// mmhq_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// ===== rtl/core/min_max_heap_queue_unit.sv =====
// ----------------------------------------------------------------------------
// min_max_heap_queue_unit
// Double-ended priority queue kept as a min-max heap in one RAM.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) carries an opcode and a
// key: insert, remove minimum or remove maximum. Every transfer on it gives
// exactly one result on the output channel (o_out_valid / i_out_stall /
// o_out_data): the removed key, a status (ok, empty, full) and the count.
// One operation runs at a time. The heap lives in a single RAM with one read
// and one write port and a registered read, and every step of the walk goes
// through it. An insert checks the parent, then climbs by grandparents; a
// removal reads the key to take and the last key, then trickles down by
// grandchildren; an empty, full or unused opcode goes straight to the result.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls with a result still held, the next finished
// result waits in the sequencer and no further item is accepted.
// Reset empties the queue (count to zero); RAM contents need no clearing.
// ----------------------------------------------------------------------------
module min_max_heap_queue_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mmhq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mmhq_pkg::t_out o_out_data
);
    import mmhq_pkg::*;

    localparam int AW = $clog2(CAPACITY + 1);
    localparam int PW = AW + 3;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_PAR = 4'd1;
    localparam logic [3:0] S_INS_CL  = 4'd2;
    localparam logic [3:0] S_INS_G   = 4'd3;
    localparam logic [3:0] S_RM_H2   = 4'd4;
    localparam logic [3:0] S_RM_H3   = 4'd5;
    localparam logic [3:0] S_RM_POS  = 4'd6;
    localparam logic [3:0] S_RM_LAST = 4'd7;
    localparam logic [3:0] S_TD_ST   = 4'd8;
    localparam logic [3:0] S_TD_SC   = 4'd9;
    localparam logic [3:0] S_TD_DEC  = 4'd10;
    localparam logic [3:0] S_TD_FIN  = 4'd11;
    localparam logic [3:0] S_TD_PAR  = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    function automatic logic lvl_odd(input logic [AW-1:0] p);
        logic odd;
        odd = 1'b0;
        for (int i = 0; i < AW; i++) begin
            if (p[i]) odd = i[0];
        end
        lvl_odd = odd;
    endfunction

    logic [3:0]         r_state, n_state;
    logic [AW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_p, n_p;
    logic [AW-1:0]      r_pos, n_pos;
    logic [AW-1:0]      r_bidx, n_bidx;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_mx, n_mx;
    logic               r_max_op, n_max_op;
    logic signed [31:0] r_key, n_key;
    logic signed [31:0] r_best, n_best;
    logic signed [31:0] r_h2, n_h2;
    logic signed [31:0] r_rem, n_rem;
    logic [1:0]         r_status, n_status;
    logic [2:0]         r_j, n_j;
    logic               r_pend, n_pend;
    logic               r_first, n_first;
    logic               r_ovalid;
    t_out               r_out;

    logic               we, re;
    logic [AW-1:0]      waddr, raddr;
    logic signed [31:0] wdata;
    logic [31:0]        rdata_raw;
    logic signed [31:0] rdata;
    logic               in_xfer;
    logic               out_load;
    logic [PW-1:0]      p2, p4, cand, cnt_x;
    logic [AW-1:0]      sel_pos;

    assign rdata      = $signed(rdata_raw);
    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);
    assign p2         = PW'(r_p) << 1;
    assign p4         = PW'(r_p) << 2;
    assign cnt_x      = PW'(r_count);
    assign sel_pos    = (r_count >= AW'(3) && !(r_h2 > rdata)) ? AW'(3) : AW'(2);

    always_comb begin
        case (r_j)
            3'd0:    cand = p2;
            3'd1:    cand = p2 + PW'(1);
            default: cand = p4 + PW'(r_j - 3'd2);
        endcase
    end

    mmhq_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY + 1)
    ) u_heap (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_p      = r_p;
        n_pos    = r_pos;
        n_bidx   = r_bidx;
        n_pidx   = r_pidx;
        n_mx     = r_mx;
        n_max_op = r_max_op;
        n_key    = r_key;
        n_best   = r_best;
        n_h2     = r_h2;
        n_rem    = r_rem;
        n_status = r_status;
        n_j      = r_j;
        n_pend   = r_pend;
        n_first  = r_first;
        we       = 1'b0;
        waddr    = r_p;
        wdata    = r_key;
        re       = 1'b0;
        raddr    = r_p;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key    = i_in_data.value;
                    n_rem    = '0;
                    n_status = ST_OK;
                    n_max_op = (i_in_data.opcode == OP_REM_MAX);
                    if (i_in_data.opcode == OP_INSERT) begin
                        if (r_count >= AW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count + AW'(1);
                            n_p     = r_count + AW'(1);
                            n_mx    = lvl_odd(r_count + AW'(1));
                            if (r_count != '0) begin
                                re      = 1'b1;
                                raddr   = (r_count + AW'(1)) >> 1;
                                n_state = S_INS_PAR;
                            end else begin
                                n_state = S_INS_CL;
                            end
                        end
                    end else if (i_in_data.opcode == OP_REM_MIN ||
                                 i_in_data.opcode == OP_REM_MAX) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else if (i_in_data.opcode == OP_REM_MAX &&
                                     r_count >= AW'(2)) begin
                            re      = 1'b1;
                            raddr   = AW'(2);
                            n_state = S_RM_H2;
                        end else begin
                            n_pos   = AW'(1);
                            re      = 1'b1;
                            raddr   = AW'(1);
                            n_state = S_RM_POS;
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INS_PAR: begin
                if (beats(rdata, r_key, r_mx)) begin
                    we    = 1'b1;
                    waddr = r_p;
                    wdata = rdata;
                    n_p   = r_p >> 1;
                    n_mx  = !r_mx;
                end
                n_state = S_INS_CL;
            end
            S_INS_CL: begin
                if (r_p > AW'(3)) begin
                    re      = 1'b1;
                    raddr   = r_p >> 2;
                    n_state = S_INS_G;
                end else begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_INS_G: begin
                we = 1'b1;
                if (beats(r_key, rdata, r_mx)) begin
                    wdata   = rdata;
                    n_p     = r_p >> 2;
                    n_state = S_INS_CL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RM_H2: begin
                n_h2    = rdata;
                re      = 1'b1;
                raddr   = AW'(3);
                n_state = S_RM_H3;
            end
            S_RM_H3: begin
                n_pos   = sel_pos;
                re      = 1'b1;
                raddr   = sel_pos;
                n_state = S_RM_POS;
            end
            S_RM_POS: begin
                n_rem   = rdata;
                re      = 1'b1;
                raddr   = r_count;
                n_state = S_RM_LAST;
            end
            S_RM_LAST: begin
                n_key   = rdata;
                n_count = r_count - AW'(1);
                n_p     = r_pos;
                n_mx    = (r_pos != AW'(1));
                n_state = (r_pos <= r_count - AW'(1)) ? S_TD_ST : S_DONE;
            end
            S_TD_ST: begin
                if (cnt_x < p2) begin
                    we      = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_j     = '0;
                    n_pend  = 1'b0;
                    n_state = S_TD_SC;
                end
            end
            S_TD_SC: begin
                // one candidate read issued per cycle, its data compared in the next cycle
                if (r_pend && (r_first || beats(rdata, r_best, r_mx))) begin
                    n_best = rdata;
                    n_bidx = r_pidx;
                end
                if (r_j < 3'd6 && cand <= cnt_x) begin
                    re      = 1'b1;
                    raddr   = AW'(cand);
                    n_pend  = 1'b1;
                    n_pidx  = AW'(cand);
                    n_first = (r_j == 3'd0);
                    n_j     = r_j + 3'd1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_TD_DEC;
                end
            end
            S_TD_DEC: begin
                we = 1'b1;
                if (beats(r_best, r_key, r_mx)) begin
                    wdata = r_best;
                    if (PW'(r_bidx) < p4) begin
                        n_state = S_TD_FIN;
                    end else begin
                        re      = 1'b1;
                        raddr   = r_bidx >> 1;
                        n_state = S_TD_PAR;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TD_FIN: begin
                we      = 1'b1;
                waddr   = r_bidx;
                n_state = S_DONE;
            end
            S_TD_PAR: begin
                if (beats(rdata, r_key, r_mx)) begin
                    we    = 1'b1;
                    waddr = r_bidx >> 1;
                    n_key = rdata;
                end
                n_p     = r_bidx;
                n_state = S_TD_ST;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_pos    <= n_pos;
        r_bidx   <= n_bidx;
        r_pidx   <= n_pidx;
        r_mx     <= n_mx;
        r_max_op <= n_max_op;
        r_key    <= n_key;
        r_best   <= n_best;
        r_h2     <= n_h2;
        r_rem    <= n_rem;
        r_status <= n_status;
        r_j      <= n_j;
        r_first  <= n_first;
        if (out_load) begin
            r_out.removed_value <= r_rem;
            r_out.status        <= r_status;
            r_out.entry_count   <= 11'(r_count);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // a max removal with two or more keys never takes the root
    a_max_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RM_LAST && r_max_op && r_count >= AW'(2)) |->
        (r_pos == AW'(2) || r_pos == AW'(3)))
        else $error("max removal picked wrong position");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= AW'(CAPACITY))
        else $error("count above capacity");

    a_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_EMPTY) |->
        (o_out_data.entry_count == '0 && o_out_data.removed_value == '0))
        else $error("empty result carries data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state != S_IDLE))
        else $error("accepted item did not start");
endmodule
